// File: rtl/sdfvsm_pkg.sv
// Shared types, codes and constants of the signed-distance volume merge block.
`default_nettype none

package sdfvsm_pkg;

  // Default grid size and job queue depth
  localparam int DIM_X_DEF       = 32;
  localparam int DIM_Y_DEF       = 32;
  localparam int DIM_Z_DEF       = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Item modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_MERGE = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECIP_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RECIP_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RECIP_Z  = 3'd5;

  localparam logic [31:0] RECIP_RST = 32'd65536;

  // Job kind handed from the front end to the memory sequencer
  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_READ,
    OP_MERGE
  } op_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [4:0]         index_x;
    logic [4:0]         index_y;
    logic [4:0]         index_z;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] sample_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               inside_res;
  } out_beat_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic [31:0]        recip_x;
    logic [31:0]        recip_y;
    logic [31:0]        recip_z;
  } cfg_t;

  // Address bits for a store of n words
  function automatic int addr_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

`default_nettype wire

// File: rtl/sdfvsm_front.sv
// Front end: accepts items, maps merge points to cells, forms voxel addresses.
`default_nettype none

module sdfvsm_front import sdfvsm_pkg::*; #(
  parameter int DIM_X = DIM_X_DEF,
  parameter int DIM_Y = DIM_Y_DEF,
  parameter int DIM_Z = DIM_Z_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  input  cfg_t      cfg_i,
  output logic      push_o,
  output op_e       push_op_o,
  output logic [addr_bits(DIM_X*DIM_Y*DIM_Z)-1:0] push_addr_o,
  output logic signed [31:0] push_value_o,
  input  wire logic full_i
);

  localparam int AW    = addr_bits(DIM_X * DIM_Y * DIM_Z);
  localparam int PLANE = DIM_Y * DIM_Z;

  // Cell check for one axis: small negative offsets land in cell 0
  function automatic logic axis_ok(input logic neg, input logic [31:0] whole, input int dim);
    return !(neg && (whole != 32'd0)) && (whole < 32'(dim));
  endfunction

  logic en;

  // Stage 1 inputs
  logic signed [31:0] pt  [3];
  logic signed [31:0] org [3];
  logic [31:0]        rcp [3];
  logic signed [32:0] diff [3];
  logic [31:0]        mag [3];
  logic               idx_ok;
  op_e                op_in;
  logic [AW-1:0]      idx_addr;

  // Stage registers
  logic               s1_valid_q;
  op_e                s1_op_q;
  logic [AW-1:0]      s1_addr_q;
  logic [2:0]         s1_neg_q;
  logic [31:0]        s1_mag_q [3];
  logic signed [31:0] s1_val_q;

  logic               s2_valid_q;
  op_e                s2_op_q;
  logic [AW-1:0]      s2_addr_q;
  logic [2:0]         s2_neg_q;
  logic [63:0]        s2_prod_q [3];
  logic signed [31:0] s2_val_q;

  logic [31:0]        whole [3];
  logic               pt_ok;
  logic [AW-1:0]      pt_addr;

  assign en         = !s2_valid_q || !full_i;
  assign in_stall_o = !en;

  always_comb begin
    pt[0]  = in_beat_i.point_x;
    pt[1]  = in_beat_i.point_y;
    pt[2]  = in_beat_i.point_z;
    org[0] = cfg_i.origin_x;
    org[1] = cfg_i.origin_y;
    org[2] = cfg_i.origin_z;
    rcp[0] = cfg_i.recip_x;
    rcp[1] = cfg_i.recip_y;
    rcp[2] = cfg_i.recip_z;
    for (int k = 0; k < 3; k++) begin
      diff[k] = {pt[k][31], pt[k]} - {org[k][31], org[k]};
      mag[k]  = diff[k][32] ? 32'(-diff[k]) : diff[k][31:0];
    end
  end

  assign idx_ok = (11'(in_beat_i.index_x) < 11'(DIM_X)) &&
                  (11'(in_beat_i.index_y) < 11'(DIM_Y)) &&
                  (11'(in_beat_i.index_z) < 11'(DIM_Z));

  assign idx_addr = AW'(in_beat_i.index_x) * AW'(PLANE) +
                    AW'(in_beat_i.index_y) * AW'(DIM_Z) + AW'(in_beat_i.index_z);

  always_comb begin
    case (in_beat_i.mode)
      MODE_WRITE: op_in = idx_ok ? OP_WRITE : OP_NONE;
      MODE_READ:  op_in = idx_ok ? OP_READ : OP_NONE;
      MODE_MERGE: op_in = OP_MERGE;
      default:    op_in = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_op_q   <= op_in;
      s1_addr_q <= idx_addr;
      s1_neg_q  <= {diff[2][32], diff[1][32], diff[0][32]};
      s1_val_q  <= in_beat_i.sample_value;
      for (int k = 0; k < 3; k++) begin
        s1_mag_q[k]  <= mag[k];
        s2_prod_q[k] <= 64'(s1_mag_q[k]) * 64'(rcp[k]);
      end
      s2_op_q   <= s1_op_q;
      s2_addr_q <= s1_addr_q;
      s2_neg_q  <= s1_neg_q;
      s2_val_q  <= s1_val_q;
    end
  end

  // Integer part of the Q32.32 product is the cell index
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      whole[k] = s2_prod_q[k][63:32];
    end
  end

  assign pt_ok = axis_ok(s2_neg_q[0], whole[0], DIM_X) &&
                 axis_ok(s2_neg_q[1], whole[1], DIM_Y) &&
                 axis_ok(s2_neg_q[2], whole[2], DIM_Z);

  assign pt_addr = AW'(whole[0]) * AW'(PLANE) + AW'(whole[1]) * AW'(DIM_Z) + AW'(whole[2]);

  assign push_o       = s2_valid_q && !full_i;
  assign push_op_o    = (s2_op_q == OP_MERGE && !pt_ok) ? OP_NONE : s2_op_q;
  assign push_addr_o  = (s2_op_q == OP_MERGE) ? pt_addr : s2_addr_q;
  assign push_value_o = s2_val_q;

endmodule

`default_nettype wire

// File: rtl/sdfvsm_fifo.sv
// Short job queue between the front end and the memory sequencer.
`default_nettype none

module sdfvsm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      pop_data_o,
  output logic                  empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [PW:0]      count_q;

  assign full_o     = (count_q == (PW+1)'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sdfvsm_back.sv
// Back end: voxel memory and the read-modify-write sequencer with output register.
`default_nettype none

module sdfvsm_back import sdfvsm_pkg::*; #(
  parameter int DIM_X = DIM_X_DEF,
  parameter int DIM_Y = DIM_Y_DEF,
  parameter int DIM_Z = DIM_Z_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic empty_i,
  output logic      pop_o,
  input  op_e       pop_op_i,
  input  wire logic [addr_bits(DIM_X*DIM_Y*DIM_Z)-1:0] pop_addr_i,
  input  wire logic signed [31:0] pop_value_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_beat_t out_beat_o
);

  localparam int VOX = DIM_X * DIM_Y * DIM_Z;
  localparam int AW  = addr_bits(VOX);

  typedef enum logic {
    ST_IDLE,
    ST_RMW
  } state_e;

  function automatic logic signed [31:0] combine(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    if (a > 0 && b > 0) begin
      return (a < b) ? a : b;
    end
    if (a <= 0 && b <= 0) begin
      return (a > b) ? a : b;
    end
    return (a > 0) ? a : b;
  endfunction

  logic [31:0]        vol_mem [VOX];
  logic signed [31:0] rdata_q;

  state_e             state_q;
  logic               out_valid_q;
  out_beat_t          out_q;
  op_e                op_q;
  logic [AW-1:0]      addr_q;
  logic signed [31:0] val_q;

  logic               slot_free;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_wa;
  logic [31:0]        mem_wd;
  logic signed [31:0] merged;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign pop_o     = (state_q == ST_IDLE) && !empty_i && slot_free;
  assign merged    = combine(rdata_q, val_q);

  assign mem_re = pop_o && (pop_op_i == OP_READ || pop_op_i == OP_MERGE);
  assign mem_we = (pop_o && pop_op_i == OP_WRITE) ||
                  (state_q == ST_RMW && slot_free && op_q == OP_MERGE);
  assign mem_wa = (state_q == ST_RMW) ? addr_q : pop_addr_i;
  assign mem_wd = (state_q == ST_RMW) ? merged : pop_value_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      vol_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= vol_mem[pop_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      op_q        <= OP_NONE;
      addr_q      <= '0;
      val_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            op_q   <= pop_op_i;
            addr_q <= pop_addr_i;
            val_q  <= pop_value_i;
            case (pop_op_i)
              OP_WRITE: begin
                out_valid_q        <= 1'b1;
                out_q.result_value <= pop_value_i;
                out_q.inside_res   <= 1'b1;
              end
              OP_READ, OP_MERGE: begin
                state_q <= ST_RMW;
              end
              default: begin
                out_valid_q        <= 1'b1;
                out_q.result_value <= '0;
                out_q.inside_res   <= 1'b0;
              end
            endcase
          end
        end
        ST_RMW: begin
          if (slot_free) begin
            out_valid_q        <= 1'b1;
            out_q.result_value <= (op_q == OP_MERGE) ? merged : rdata_q;
            out_q.inside_res   <= 1'b1;
            state_q            <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

`default_nettype wire

// File: rtl/sdf_volume_scatter_merge.sv
// Top level of the signed-distance volume scatter-merge block.
//
// Channels: the input channel takes one item per beat (in_valid_i/in_stall_o,
// payload in_beat_i): write a voxel by index, read a voxel by index, or merge a
// sample at a Q16.16 point. Every item yields exactly one result beat on the
// output channel (out_valid_o/out_stall_i, payload out_beat_o), in order.
// Configuration (origin and reciprocal step per axis) is written through
// cfg_valid_i/cfg_ready_o with cfg_index_i/cfg_data_i; the user must write it
// only while idle, and the block itself leaves this unchecked. Throughput: one
// write or dropped item per cycle while the output is not stalled; a read or
// merge holds the read-modify-write sequencer on the single-port voxel memory
// until its result is registered, and no new job leaves the queue before then.
// The front end (cell mapping, two register stages) runs ahead of the memory
// sequencer through a short job queue; it stalls only when that queue fills.
// Reset: control state clears, configuration returns to origin 0 and
// reciprocal 1.0; voxel contents are undefined until written (no clear pass).
// A stalled output beat holds in the output register while the block keeps
// accepting items until the queue is full.
`default_nettype none

module sdf_volume_scatter_merge import sdfvsm_pkg::*; #(
  parameter int DIM_X       = DIM_X_DEF,
  parameter int DIM_Y       = DIM_Y_DEF,
  parameter int DIM_Z       = DIM_Z_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  in_beat_t                  in_beat_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_beat_t                 out_beat_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]          cfg_data_i
);

  localparam int AW = addr_bits(DIM_X * DIM_Y * DIM_Z);

  // One queued memory job
  typedef struct packed {
    op_e                op;
    logic [AW-1:0]      addr;
    logic signed [31:0] value;
  } job_t;

  cfg_t cfg_q;

  job_t push_job, pop_job;
  logic push, full, pop, empty;

  // Config registers are always ready; a write beyond the list is dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x <= '0;
      cfg_q.origin_y <= '0;
      cfg_q.origin_z <= '0;
      cfg_q.recip_x  <= RECIP_RST;
      cfg_q.recip_y  <= RECIP_RST;
      cfg_q.recip_z  <= RECIP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ORIGIN_X: cfg_q.origin_x <= cfg_data_i;
        CFG_ORIGIN_Y: cfg_q.origin_y <= cfg_data_i;
        CFG_ORIGIN_Z: cfg_q.origin_z <= cfg_data_i;
        CFG_RECIP_X:  cfg_q.recip_x  <= cfg_data_i;
        CFG_RECIP_Y:  cfg_q.recip_y  <= cfg_data_i;
        CFG_RECIP_Z:  cfg_q.recip_z  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sdfvsm_front #(
    .DIM_X (DIM_X),
    .DIM_Y (DIM_Y),
    .DIM_Z (DIM_Z)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_beat_i    (in_beat_i),
    .cfg_i        (cfg_q),
    .push_o       (push),
    .push_op_o    (push_job.op),
    .push_addr_o  (push_job.addr),
    .push_value_o (push_job.value),
    .full_i       (full)
  );

  sdfvsm_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (empty)
  );

  sdfvsm_back #(
    .DIM_X (DIM_X),
    .DIM_Y (DIM_Y),
    .DIM_Z (DIM_Z)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_o       (pop),
    .pop_op_i    (pop_job.op),
    .pop_addr_i  (pop_job.addr),
    .pop_value_i (pop_job.value),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

`default_nettype wire

// File: rtl/sdfvsm_chk.sv
// Port-level checker for the volume merge block, bound to the top level.
`default_nettype none

module sdfvsm_chk import sdfvsm_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input out_beat_t                 out_beat_o
);

  logic       in_acc, out_acc;
  logic [7:0] inflight_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Items accepted and not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_q <= inflight_q + 8'd1;
    end else if (out_acc && !in_acc) begin
      inflight_q <= inflight_q - 8'd1;
    end
  end

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat withdrawn while stalled");

  a_out_beat_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_beat_o))
    else $error("output beat changed while stalled");

  a_dropped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_beat_o.inside_res |-> out_beat_o.result_value == 32'sd0)
    else $error("dropped item carries a nonzero value");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != 8'd0)
    else $error("result beat without an accepted item");

endmodule

bind sdf_volume_scatter_merge sdfvsm_chk u_sdfvsm_chk (.*);

`default_nettype wire
